@@ hw/rtl/mcpf_pkg.sv @@
package mcpf_pkg;

  localparam int NUM_PIPES_DEF = 64;
  localparam int BUF_DEPTH_DEF = 4096;
  localparam int ID_WIDTH_DEF  = 16;

  localparam int FUNC_W   = 3;
  localparam int PIPEID_W = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;

  localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_OPEN   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_PIPE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EOF        = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NO_READERS = 3'd6;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [PIPEID_W-1:0] pipe_id;
    logic                writer_end;
    logic [7:0]          data_in;
    logic                last_byte;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PIPEID_W-1:0] new_id;
    logic [7:0]          data_out;
    logic                request_done;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch request, start lookup
    logic execute;  // apply the operation to slot state
    logic finish;   // load the response register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

endpackage

@@ hw/rtl/mcpf_if.sv @@
interface mcpf_req_if
  import mcpf_pkg::*;
  ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mcpf_rsp_if
  import mcpf_pkg::*;
  ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/mcpf_ram.sv @@
module mcpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/mcpf_ctrl.sv @@
module mcpf_ctrl
  import mcpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DATA  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  // A new request may enter once the previous response register is free or
  // being drained.
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_FETCH;
        end
      end
      // The matched slot record is read from its memory here.
      S_FETCH: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = S_DATA;
      end
      S_DATA: begin
        cmd.finish     = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

@@ hw/rtl/mcpf_dp.sv @@
module mcpf_dp
  import mcpf_pkg::*;
#(
  parameter int NUM_PIPES = NUM_PIPES_DEF,
  parameter int BUF_DEPTH = BUF_DEPTH_DEF,
  parameter int ID_WIDTH  = ID_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  req_t     req_in,
  output rsp_t     rsp
);
  localparam int SW = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int PW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FW = $clog2(BUF_DEPTH + 1);
  localparam int AW = $clog2(NUM_PIPES * BUF_DEPTH);
  localparam logic [COUNT_W-1:0] CNT_MAX = '1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_PIPES - 1);

  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    logic [PW-1:0]       rd_ptr;
    logic [PW-1:0]       wr_ptr;
    logic [FW-1:0]       fill;
    logic [COUNT_W-1:0]  rd_cnt;
    logic [COUNT_W-1:0]  wr_cnt;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  // Only the in-use flags are registers; everything else per slot lives in a
  // record memory, and a record is only looked at while its slot is in use.
  logic [NUM_PIPES-1:0] in_use;
  logic [ID_WIDTH-1:0]  next_id;

  req_t                req;
  logic [ID_WIDTH-1:0] key;

  // Lookup walks the record memory one slot per cycle, lowest first.
  logic          scan_run;
  logic [SW-1:0] scan_addr;
  logic          cmp_valid;
  logic [SW-1:0] cmp_addr;
  logic          hit_found;
  logic [SW-1:0] hit_slot;
  logic          free_found;
  logic [SW-1:0] free_slot;

  logic          rec_we;
  logic [SW-1:0] rec_waddr, rec_raddr;
  slot_rec_t     rec_wdata, rec;

  assign key       = ID_WIDTH'(req.pipe_id);
  assign rec_raddr = scan_run ? scan_addr : hit_slot;

  mcpf_ram #(.WIDTH(REC_W), .DEPTH(NUM_PIPES)) u_slots (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec)
  );

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  assign stat.scan_done = cmp_valid && (cmp_addr == LAST_SLOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_run  <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        scan_run <= 1'b1;
      end else if (scan_run && scan_addr == LAST_SLOT) begin
        scan_run <= 1'b0;
      end
      cmp_valid <= scan_run;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req       <= req_in;
      scan_addr <= '0;
      hit_found <= 1'b0;
      hit_slot  <= '0;
    end else begin
      if (scan_run && scan_addr != LAST_SLOT) begin
        scan_addr <= scan_addr + SW'(1);
      end
      if (cmp_valid && !hit_found && in_use[cmp_addr] && rec.id == key && key != '0) begin
        hit_found <= 1'b1;
        hit_slot  <= cmp_addr;
      end
    end
    cmp_addr <= scan_addr;
  end

  // Byte store; the read result is registered by the RAM and picked up in
  // the cycle after execute.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  mcpf_ram #(.WIDTH(8), .DEPTH(NUM_PIPES * BUF_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.data_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [STATUS_W-1:0] st;
  logic                do_read, do_write, do_create, do_open, do_close;
  logic [COUNT_W-1:0]  rc_new, wc_new;
  logic [ID_WIDTH-1:0] id_inc;

  assign ram_waddr = AW'(hit_slot) * AW'(BUF_DEPTH) + AW'(rec.wr_ptr);
  assign ram_raddr = AW'(hit_slot) * AW'(BUF_DEPTH) + AW'(rec.rd_ptr);
  assign ram_we    = cmd.execute && do_write;
  assign id_inc    = next_id + ID_WIDTH'(1);

  always_comb begin
    st        = ST_OK;
    do_read   = 1'b0;
    do_write  = 1'b0;
    do_create = 1'b0;
    do_open   = 1'b0;
    do_close  = 1'b0;
    rc_new    = rec.rd_cnt;
    wc_new    = rec.wr_cnt;
    case (req.func)
      FUNC_CREATE: begin
        if (free_found) do_create = 1'b1;
        else st = ST_TABLE_FULL;
      end
      FUNC_OPEN: begin
        if (!hit_found) st = ST_NO_PIPE;
        else begin
          do_open = 1'b1;
          if (req.writer_end) begin
            if (wc_new != CNT_MAX) wc_new = wc_new + COUNT_W'(1);
          end else begin
            if (rc_new != CNT_MAX) rc_new = rc_new + COUNT_W'(1);
          end
        end
      end
      FUNC_CLOSE: begin
        if (!hit_found) st = ST_NO_PIPE;
        else begin
          do_close = 1'b1;
          if (req.writer_end) begin
            if (wc_new != '0) wc_new = wc_new - COUNT_W'(1);
          end else begin
            if (rc_new != '0) rc_new = rc_new - COUNT_W'(1);
          end
        end
      end
      FUNC_READ: begin
        if (!hit_found) st = ST_NO_PIPE;
        else if (rec.fill == '0) st = (rec.wr_cnt == '0) ? ST_EOF : ST_EMPTY;
        else do_read = 1'b1;
      end
      FUNC_WRITE: begin
        if (!hit_found) st = ST_NO_PIPE;
        else if (rec.rd_cnt == '0) st = ST_NO_READERS;
        else if (rec.fill == FW'(BUF_DEPTH)) st = ST_FULL;
        else do_write = 1'b1;
      end
      default: st = ST_NO_PIPE;
    endcase
  end

  assign rec_we = cmd.execute && (do_create || do_open || do_close || do_read || do_write);

  always_comb begin
    rec_wdata        = rec;
    rec_wdata.rd_cnt = rc_new;
    rec_wdata.wr_cnt = wc_new;
    rec_waddr        = hit_slot;
    if (do_create) begin
      rec_wdata    = '0;
      rec_wdata.id = next_id;
      rec_waddr    = free_slot;
    end
    if (do_read) begin
      rec_wdata.rd_ptr = (rec.rd_ptr == PW'(BUF_DEPTH - 1)) ? '0 : rec.rd_ptr + PW'(1);
      rec_wdata.fill   = rec.fill - FW'(1);
    end
    if (do_write) begin
      rec_wdata.wr_ptr = (rec.wr_ptr == PW'(BUF_DEPTH - 1)) ? '0 : rec.wr_ptr + PW'(1);
      rec_wdata.fill   = rec.fill + FW'(1);
    end
  end

  // A freed slot keeps a stale record; create rewrites the whole record.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use  <= '0;
      next_id <= ID_WIDTH'(1);
    end else if (cmd.execute) begin
      if (do_create) begin
        in_use[free_slot] <= 1'b1;
        next_id <= (id_inc == '0) ? ID_WIDTH'(1) : id_inc;
      end
      if (do_close && rc_new == '0 && wc_new == '0) begin
        in_use[hit_slot] <= 1'b0;
      end
    end
  end

  logic [STATUS_W-1:0] st_q;
  logic [ID_WIDTH-1:0] nid_q;
  logic                rd_q;

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      st_q  <= st;
      nid_q <= do_create ? next_id : '0;
      rd_q  <= do_read;
    end
    if (cmd.finish) begin
      rsp.status       <= st_q;
      rsp.new_id       <= PIPEID_W'(nid_q);
      rsp.data_out     <= rd_q ? ram_rdata : 8'd0;
      rsp.request_done <= req.last_byte || (st_q != ST_OK);
    end
  end
endmodule

@@ hw/rtl/multi_channel_pipe_fifo.sv @@
// Channel | Dir | Payload
// req     | in  | func, pipe_id, writer_end, data_in, last_byte
// rsp     | out | status, new_id, data_out, request_done
//
// Each request goes through these steps from acceptance to its response:
// the slot record memory is scanned one slot per cycle through its registered
// read port, the matched record is read, slot state is updated and the byte
// store is addressed, and the byte read is taken into the response.
// Reset is synchronous, clears the in-use flags and sets the id counter to 1;
// the slot records and the byte store are not cleared.
// A stalled response holds in its register and blocks the next request.
module multi_channel_pipe_fifo
  import mcpf_pkg::*;
#(
  parameter int NUM_PIPES = NUM_PIPES_DEF,
  parameter int BUF_DEPTH = BUF_DEPTH_DEF,
  parameter int ID_WIDTH  = ID_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  mcpf_req_if.sink   req,
  mcpf_rsp_if.source rsp
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  mcpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mcpf_dp #(
    .NUM_PIPES (NUM_PIPES),
    .BUF_DEPTH (BUF_DEPTH),
    .ID_WIDTH  (ID_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .req_in (req.payload),
    .rsp    (rsp.payload)
  );
endmodule

@@ hw/rtl/mcpf_checker.sv @@
module mcpf_checker
  import mcpf_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_payload
);
  // Requests are handled one at a time: no accept the cycle after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted back to back");

  // A response is never offered the cycle right after acceptance.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !($rose(rsp_valid)))
    else $error("response too early");

  a_done: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_payload.status != ST_OK) |-> rsp_payload.request_done)
    else $error("error status without request_done");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
    else $error("stalled response changed");
endmodule

bind multi_channel_pipe_fifo mcpf_checker u_mcpf_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

@@ verif/multi_channel_pipe_fifo_checker.sv @@
module multi_channel_pipe_fifo_checker
  import mcpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mcpf_req_if        req,
  mcpf_rsp_if        rsp,
  output int         error_count,
  output int         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPIPE = NUM_PIPES_DEF;
  localparam int DEPTH = BUF_DEPTH_DEF;

  logic        in_use [NPIPE];
  logic [15:0] pid_of [NPIPE];
  int          rd_ptr [NPIPE];
  int          wr_ptr [NPIPE];
  int          fill   [NPIPE];
  int          readers[NPIPE];
  int          writers[NPIPE];
  logic [7:0]  bytes  [NPIPE][DEPTH];
  logic [15:0] id_counter;
  rsp_t        expected_rsp[$];

  function automatic int find_pipe(logic [15:0] id);
    if (id == 0) return -1;
    for (int i = 0; i < NPIPE; i++)
      if (in_use[i] && pid_of[i] == id) return i;
    return -1;
  endfunction

  function automatic void free_pipe(int s);
    in_use[s] = 0; pid_of[s] = 0; rd_ptr[s] = 0; wr_ptr[s] = 0;
    fill[s] = 0; readers[s] = 0; writers[s] = 0;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int s;
    o = '0;
    o.status = ST_OK;
    s = -1;
    case (r.func)
      FUNC_CREATE: begin
        for (int i = 0; i < NPIPE; i++)
          if (!in_use[i]) begin s = i; break; end
        if (s < 0) begin
          o.status = ST_TABLE_FULL;
        end else begin
          free_pipe(s);
          in_use[s] = 1;
          pid_of[s] = id_counter;
          o.new_id = id_counter;
          id_counter = id_counter + 1;
          if (id_counter == 0) id_counter = 1;
        end
      end
      FUNC_OPEN, FUNC_CLOSE, FUNC_READ, FUNC_WRITE: begin
        s = find_pipe(r.pipe_id);
        if (s < 0) begin
          o.status = ST_NO_PIPE;
        end else if (r.func == FUNC_OPEN) begin
          if (r.writer_end) begin
            if (writers[s] < 255) writers[s]++;
          end else if (readers[s] < 255) begin
            readers[s]++;
          end
        end else if (r.func == FUNC_CLOSE) begin
          if (r.writer_end) begin
            if (writers[s] > 0) writers[s]--;
          end else if (readers[s] > 0) begin
            readers[s]--;
          end
          if (readers[s] == 0 && writers[s] == 0) free_pipe(s);
        end else if (r.func == FUNC_READ) begin
          if (fill[s] == 0) begin
            o.status = (writers[s] == 0) ? ST_EOF : ST_EMPTY;
          end else begin
            o.data_out = bytes[s][rd_ptr[s]];
            rd_ptr[s] = (rd_ptr[s] + 1) % DEPTH;
            fill[s]--;
          end
        end else begin
          if (readers[s] == 0) begin
            o.status = ST_NO_READERS;
          end else if (fill[s] >= DEPTH) begin
            o.status = ST_FULL;
          end else begin
            bytes[s][wr_ptr[s]] = r.data_in;
            wr_ptr[s] = (wr_ptr[s] + 1) % DEPTH;
            fill[s]++;
          end
        end
      end
      default: o.status = ST_NO_PIPE;
    endcase
    o.request_done = r.last_byte || (o.status != ST_OK);
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < NPIPE; i++) free_pipe(i);
      id_counter = 1;
      expected_rsp.delete();
      error_count = 0;
      pending_count = 0;
    end else begin
      if (req.valid && req.ready)
        expected_rsp.push_back(apply_request(req.payload));
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected response %p", $time, rsp.payload);
          error_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (want.status !== rsp.payload.status ||
              want.new_id !== rsp.payload.new_id ||
              want.data_out !== rsp.payload.data_out ||
              want.request_done !== rsp.payload.request_done) begin
            $display("%0t: expected %p, actual %p", $time, want, rsp.payload);
            error_count++;
          end
        end
      end
      pending_count = expected_rsp.size();
    end
  end
endmodule

@@ verif/multi_channel_pipe_fifo_tb.sv @@
module multi_channel_pipe_fifo_tb;
  import mcpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   error_count;
  int   pending_count;
  int   cycle_count;
  logic [15:0] known_ids[$];

  mcpf_req_if req ();
  mcpf_rsp_if rsp ();

  multi_channel_pipe_fifo dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  multi_channel_pipe_fifo_checker checker_i (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .error_count(error_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop; each request also waits out random idling on both sides.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The response side stalls a random number of cycles before each response.
  initial begin
    int wait_cycles;
    rsp.ready <= 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (wait_cycles > 0) begin
        rsp.ready <= 0;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp.ready <= 1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
    end
  end

  // Remember ids that creates hand out so later requests can hit live pipes.
  always @(posedge clk)
    if (!rst && rsp.valid && rsp.ready && rsp.payload.new_id != 0)
      known_ids.push_back(rsp.payload.new_id);

  task automatic send_request(logic [2:0] func, logic [15:0] id, logic wr,
                              logic [7:0] data, logic last);
    int wait_cycles;
    wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if (wait_cycles > 0) begin
      req.valid <= 0;
      repeat (wait_cycles) @(posedge clk);
    end
    req.payload <= '{func: func, pipe_id: id, writer_end: wr, data_in: data,
                     last_byte: last};
    req.valid <= 1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_id();
    if (known_ids.size() == 0 || $urandom_range(0, 9) == 0) return 16'($urandom);
    return known_ids[$urandom_range(0, known_ids.size() - 1)];
  endfunction

  initial begin
    logic [15:0] id;
    int pick;
    cycle_count = 0;
    rst <= 1;
    req.valid <= 0;
    req.payload <= '0;
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: lookups of missing pipes, unknown funcs, and one pipe life.
    send_request(FUNC_READ, 16'h0000, 0, 8'h00, 0);
    send_request(FUNC_WRITE, 16'hFFFF, 1, 8'hFF, 1);
    send_request(3'd5, 16'h0001, 0, 8'h00, 0);
    send_request(3'd7, 16'h0001, 1, 8'hFF, 1);
    send_request(FUNC_CREATE, 16'h0000, 0, 8'h00, 1);
    send_request(FUNC_READ, 16'h0001, 0, 8'h00, 1);
    send_request(FUNC_WRITE, 16'h0001, 0, 8'hA5, 1);
    send_request(FUNC_OPEN, 16'h0001, 1, 8'h00, 0);
    send_request(FUNC_READ, 16'h0001, 0, 8'h00, 0);
    send_request(FUNC_OPEN, 16'h0001, 0, 8'h00, 0);
    send_request(FUNC_WRITE, 16'h0001, 0, 8'h00, 0);
    send_request(FUNC_WRITE, 16'h0001, 0, 8'hFF, 1);
    send_request(FUNC_READ, 16'h0001, 0, 8'h00, 0);
    send_request(FUNC_READ, 16'h0001, 0, 8'h00, 1);
    send_request(FUNC_CLOSE, 16'h0001, 1, 8'h00, 0);
    send_request(FUNC_CLOSE, 16'h0001, 1, 8'h00, 0);
    send_request(FUNC_CLOSE, 16'h0001, 0, 8'h00, 1);
    send_request(FUNC_OPEN, 16'h0001, 0, 8'h00, 0);
    // Closing a never-opened pipe frees it.
    send_request(FUNC_CREATE, 16'h0000, 0, 8'h00, 0);
    send_request(FUNC_CLOSE, 16'h0002, 0, 8'h00, 1);
    // Saturate the reader count.
    send_request(FUNC_CREATE, 16'h0000, 0, 8'h00, 0);
    repeat (257) send_request(FUNC_OPEN, 16'h0003, 0, 8'h00, 0);
    // Fill the table to get table-full.
    repeat (65) send_request(FUNC_CREATE, 16'h0000, 0, 8'h00, 0);

    // Random: mostly open/write/read on live pipes, some create/close and noise.
    repeat (600) begin
      pick = $urandom_range(0, 99);
      id = pick_id();
      if (pick < 8)
        send_request(FUNC_CREATE, 16'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
      else if (pick < 25)
        send_request(FUNC_OPEN, id, 1'($urandom), 8'($urandom), 1'($urandom));
      else if (pick < 37)
        send_request(FUNC_CLOSE, id, 1'($urandom), 8'($urandom), 1'($urandom));
      else if (pick < 64)
        send_request(FUNC_WRITE, id, 1'($urandom), 8'($urandom), 1'($urandom));
      else if (pick < 95)
        send_request(FUNC_READ, id, 1'($urandom), 8'($urandom), 1'($urandom));
      else
        send_request(3'($urandom_range(5, 7)), 16'($urandom), 1'($urandom), 8'($urandom),
                     1'($urandom));
    end
    req.valid <= 0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/mcpf_pkg.sv
hw/rtl/mcpf_if.sv
hw/rtl/mcpf_ram.sv
hw/rtl/mcpf_ctrl.sv
hw/rtl/mcpf_dp.sv
hw/rtl/multi_channel_pipe_fifo.sv
hw/rtl/mcpf_checker.sv
verif/multi_channel_pipe_fifo_checker.sv
verif/multi_channel_pipe_fifo_tb.sv
